// ===== src/ipmd_pkg.sv =====
`timescale 1ns / 1ps

package ipmd_pkg;

	// Bridge compare geometry and accumulator fixed point.
	localparam int PWM_W      = 15;
	localparam int PWM_TOP    = 16799;
	localparam int FRAC_BITS  = 10;
	localparam int WHEELS     = 4;
	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int VOLT_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Derived arithmetic widths.
	localparam int ERR_W  = SPEED_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = GAIN_W + 1 + DIFF_W;
	localparam int IP_W   = GAIN_W + 1 + ERR_W;
	localparam int ACC_W  = PWM_W + 1 + FRAC_BITS;
	localparam int SUM_W  = PP_W + 2;
	localparam int DRV_W  = ACC_W - FRAC_BITS;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN   = 2'd0,
		CFG_INTEG_GAIN  = 2'd1,
		CFG_PWM_LIMIT   = 2'd2,
		CFG_MIN_VOLTAGE = 2'd3
	} cfg_idx_t;

	// One control tick.
	typedef struct packed {
		logic signed [SPEED_W-1:0] wheel_speed_a;
		logic signed [SPEED_W-1:0] wheel_speed_b;
		logic signed [SPEED_W-1:0] wheel_speed_c;
		logic signed [SPEED_W-1:0] wheel_speed_d;
		logic signed [SPEED_W-1:0] target_speed_a;
		logic signed [SPEED_W-1:0] target_speed_b;
		logic signed [SPEED_W-1:0] target_speed_c;
		logic signed [SPEED_W-1:0] target_speed_d;
		logic        [VOLT_W-1:0]  supply_volts;
		logic                      drive_enable;
		logic                      stop_request;
	} in_req_t;

	// Eight bridge compares for one tick.
	typedef struct packed {
		logic [PWM_W-1:0] pwm_a_first;
		logic [PWM_W-1:0] pwm_a_second;
		logic [PWM_W-1:0] pwm_b_first;
		logic [PWM_W-1:0] pwm_b_second;
		logic [PWM_W-1:0] pwm_c_first;
		logic [PWM_W-1:0] pwm_c_second;
		logic [PWM_W-1:0] pwm_d_first;
		logic [PWM_W-1:0] pwm_d_second;
	} out_req_t;

endpackage

// ===== src/incremental_pi_motor_drive.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | in_data  (ipmd_pkg::in_req_t)
// out      | output    | out_valid/out_stall| out_data (ipmd_pkg::out_req_t)
// cfg      | input     | cfg_wen            | cfg_index, cfg_data
//
// A request is taken every cycle while in_stall is low; its result passes through the stage-one,
// stage-two and output registers before it is offered. The three stages are the gain multipliers,
// the accumulator add and clamp (the only feedback loop) and the compare register.
// Reset clears the accumulators, stored errors and pipeline valid flags, and loads register defaults.
// When the output stalls, the stages behind it keep filling until all three are full.

module incremental_pi_motor_drive (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ipmd_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ipmd_pkg::out_req_t out_data,
	input  logic               cfg_wen,
	input  logic [ipmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipmd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipmd_pkg::*;

	// Configuration registers.
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] integ_gain_q;
	logic [PWM_W-1:0]  pwm_limit_q;
	logic [VOLT_W-1:0] min_voltage_q;

	// Controller state per wheel.
	logic signed [ACC_W-1:0] acc_q      [WHEELS];
	logic signed [ERR_W-1:0] prev_err_q [WHEELS];

	// Pipeline registers.
	logic                    valid_s1;
	logic                    off_s1;
	logic signed [PP_W-1:0]  pprod_s1 [WHEELS];
	logic signed [IP_W-1:0]  iprod_s1 [WHEELS];
	logic                    valid_s2;
	logic                    off_s2;
	logic signed [ACC_W-1:0] acc_s2   [WHEELS];
	logic                    out_valid_q;
	out_req_t                out_data_q;

	// Combinational signals.
	logic                     adv_out, adv_s2, adv_s1, take_in, off_in;
	logic signed [SPEED_W-1:0] meas    [WHEELS];
	logic signed [SPEED_W-1:0] target  [WHEELS];
	logic signed [ERR_W-1:0]  err     [WHEELS];
	logic signed [DIFF_W-1:0] diff    [WHEELS];
	logic signed [PP_W-1:0]   pprod   [WHEELS];
	logic signed [IP_W-1:0]   iprod   [WHEELS];
	logic signed [SUM_W-1:0]  sum     [WHEELS];
	logic signed [ACC_W-1:0]  acc_nxt [WHEELS];
	logic [PWM_W-1:0]         lim;
	logic signed [ACC_W-1:0]  bound;
	logic signed [ACC_W-1:0]  rnd     [WHEELS];
	logic signed [DRV_W-1:0]  drive   [WHEELS];
	logic [PWM_W-1:0]         first   [WHEELS];
	logic [PWM_W-1:0]         second  [WHEELS];

	// Stage advance: each stage moves when the one ahead is free or moving.
	assign adv_out   = !out_valid_q || !out_stall;
	assign adv_s2    = !valid_s2 || adv_out;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign take_in   = in_valid && adv_s1;
	assign in_stall  = !adv_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Drive is off on low supply, disable or stop.
	assign off_in = (in_data.supply_volts < min_voltage_q) || !in_data.drive_enable
		|| in_data.stop_request;

	// Unpack the request into per-wheel lanes.
	always_comb begin
		meas[0]   = in_data.wheel_speed_a;
		meas[1]   = in_data.wheel_speed_b;
		meas[2]   = in_data.wheel_speed_c;
		meas[3]   = in_data.wheel_speed_d;
		target[0] = in_data.target_speed_a;
		target[1] = in_data.target_speed_b;
		target[2] = in_data.target_speed_c;
		target[3] = in_data.target_speed_d;
	end

	// Error, error change and both gain products.
	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			err[w]   = ERR_W'(target[w]) - ERR_W'(meas[w]);
			diff[w]  = DIFF_W'(err[w]) - DIFF_W'(prev_err_q[w]);
			pprod[w] = PP_W'($signed({1'b0, prop_gain_q}) * diff[w]);
			iprod[w] = IP_W'($signed({1'b0, integ_gain_q}) * err[w]);
		end
	end

	// Saturation bound, capped at the top count.
	assign lim   = (pwm_limit_q > PWM_W'(PWM_TOP)) ? PWM_W'(PWM_TOP) : pwm_limit_q;
	assign bound = $signed({1'b0, lim, {FRAC_BITS{1'b0}}});

	// Accumulate and clamp.
	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			sum[w] = SUM_W'(acc_q[w]) + SUM_W'(pprod_s1[w]) + SUM_W'(iprod_s1[w]);
			if (sum[w] > SUM_W'(bound)) begin
				acc_nxt[w] = bound;
			end else if (sum[w] < -SUM_W'(bound)) begin
				acc_nxt[w] = -bound;
			end else begin
				acc_nxt[w] = ACC_W'(sum[w]);
			end
		end
	end

	// Truncate toward zero and split the drive onto the bridge pair.
	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			rnd[w]    = acc_s2[w] + (acc_s2[w][ACC_W-1] ?
				ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
			drive[w]  = rnd[w][ACC_W-1:FRAC_BITS];
			first[w]  = PWM_W'(PWM_TOP);
			second[w] = PWM_W'(PWM_TOP);
			if (!off_s2) begin
				if (drive[w][DRV_W-1]) begin
					second[w] = PWM_W'(DRV_W'(PWM_TOP) + drive[w]);
				end else begin
					first[w] = PWM_W'(DRV_W'(PWM_TOP) - drive[w]);
				end
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			pwm_limit_q   <= PWM_W'(16700);
			min_voltage_q <= VOLT_W'(10);
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PROP_GAIN:   prop_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_PWM_LIMIT:   pwm_limit_q   <= cfg_data[PWM_W-1:0];
				CFG_MIN_VOLTAGE: min_voltage_q <= cfg_data[VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller state: errors update on acceptance, accumulators on entry to stage two, both only while drive is on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WHEELS; w++) begin
				acc_q[w]      <= '0;
				prev_err_q[w] <= '0;
			end
		end else begin
			for (int w = 0; w < WHEELS; w++) begin
				if (take_in && !off_in) begin
					prev_err_q[w] <= err[w];
				end
				if (valid_s1 && adv_s2 && !off_s1) begin
					acc_q[w] <= acc_nxt[w];
				end
			end
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (take_in) begin
			off_s1 <= off_in;
			for (int w = 0; w < WHEELS; w++) begin
				pprod_s1[w] <= pprod[w];
				iprod_s1[w] <= iprod[w];
			end
		end
		if (valid_s1 && adv_s2) begin
			off_s2 <= off_s1;
			for (int w = 0; w < WHEELS; w++) begin
				acc_s2[w] <= off_s1 ? acc_q[w] : acc_nxt[w];
			end
		end
		if (valid_s2 && adv_out) begin
			out_data_q.pwm_a_first  <= first[0];
			out_data_q.pwm_a_second <= second[0];
			out_data_q.pwm_b_first  <= first[1];
			out_data_q.pwm_b_second <= second[1];
			out_data_q.pwm_c_first  <= first[2];
			out_data_q.pwm_c_second <= second[2];
			out_data_q.pwm_d_first  <= first[3];
			out_data_q.pwm_d_second <= second[3];
		end
	end

endmodule

// ===== src/ipmd_checker.sv =====
`timescale 1ns / 1ps

module ipmd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input ipmd_pkg::out_req_t out_data
);
	import ipmd_pkg::*;

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The input only backs up behind a stalled, occupied output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// No result is offered in the cycle after reset has been seen held.
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result offered during reset");

	// At most one compare of each bridge pair drops below the top count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pwm_a_first == PWM_W'(PWM_TOP)
			|| out_data.pwm_a_second == PWM_W'(PWM_TOP))
		&& (out_data.pwm_b_first == PWM_W'(PWM_TOP)
			|| out_data.pwm_b_second == PWM_W'(PWM_TOP))
		&& (out_data.pwm_c_first == PWM_W'(PWM_TOP)
			|| out_data.pwm_c_second == PWM_W'(PWM_TOP))
		&& (out_data.pwm_d_first == PWM_W'(PWM_TOP)
			|| out_data.pwm_d_second == PWM_W'(PWM_TOP)))
		else $error("both compares of a bridge pair are active");

	// A request accepted while no result is offered yields a result if the output does not stall in between.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("result missing after three cycles");

endmodule

bind incremental_pi_motor_drive ipmd_checker u_ipmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== test/incremental_pi_motor_drive_tb.sv =====
`timescale 1ns / 1ps

module incremental_pi_motor_drive_tb;
	import ipmd_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_TICKS = 142;

	localparam logic [PWM_W-1:0] CMP_TOP = PWM_W'(PWM_TOP);
	localparam out_req_t PWM_ALL_TOP = {8{CMP_TOP}};

	// The eight compares viewed as an array; index 7 is pwm_a_first.
	typedef logic [7:0][PWM_W-1:0] pwm_set_t;

	// One line of the directed part: either a register write or a control tick.
	typedef struct {
		bit       is_cfg;
		cfg_idx_t idx;
		logic [CFG_DATA_W-1:0] val;
		in_req_t  tick;
		bit       typed;
		out_req_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_req_t in_data;
	logic out_valid;
	logic out_stall;
	out_req_t out_data;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Register copies and per-wheel PI state of the controller.
	longint kp, ki, lim_reg, volt_floor;
	longint wheel_acc [WHEELS];
	longint wheel_err_prev [WHEELS];

	out_req_t pwm_expected [$];
	int fault_count;
	int checked_count;
	int ticks_sent;
	int idle_pct;
	int stall_pct;

	string pwm_names [8] = '{"pwm_a_first", "pwm_a_second", "pwm_b_first", "pwm_b_second",
		"pwm_c_first", "pwm_c_second", "pwm_d_first", "pwm_d_second"};

	dir_row_t dir_rows [23];

	incremental_pi_motor_drive u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic in_req_t mk_tick(int ma, int mb, int mc, int md, int ta, int tb, int tc,
		int td, int volts, bit en, bit stop);
		in_req_t t;
		t.wheel_speed_a  = 16'(ma);
		t.wheel_speed_b  = 16'(mb);
		t.wheel_speed_c  = 16'(mc);
		t.wheel_speed_d  = 16'(md);
		t.target_speed_a = 16'(ta);
		t.target_speed_b = 16'(tb);
		t.target_speed_c = 16'(tc);
		t.target_speed_d = 16'(td);
		t.supply_volts   = 8'(volts);
		t.drive_enable   = en;
		t.stop_request   = stop;
		return t;
	endfunction

	function automatic out_req_t mk_pwm(int af, int as, int bf, int bs, int cf, int cs,
		int df, int ds);
		return {PWM_W'(af), PWM_W'(as), PWM_W'(bf), PWM_W'(bs),
			PWM_W'(cf), PWM_W'(cs), PWM_W'(df), PWM_W'(ds)};
	endfunction

	function automatic dir_row_t row_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		r.tick   = '0;
		r.typed  = 1'b0;
		r.want   = PWM_ALL_TOP;
		return r;
	endfunction

	function automatic dir_row_t row_tick(in_req_t t, bit typed, out_req_t want);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.idx    = CFG_PROP_GAIN;
		r.val    = '0;
		r.tick   = t;
		r.typed  = typed;
		r.want   = want;
		return r;
	endfunction

	// Incremental PI step over all four wheels; updates the state unless drive is off.
	function automatic out_req_t pi_tick(in_req_t t);
		logic signed [SPEED_W-1:0] meas [WHEELS];
		logic signed [SPEED_W-1:0] goal [WHEELS];
		pwm_set_t cmp;
		longint err, lim_eff, bound, acc, mag, drv;
		bit off;
		int w;
		meas = '{t.wheel_speed_a, t.wheel_speed_b, t.wheel_speed_c, t.wheel_speed_d};
		goal = '{t.target_speed_a, t.target_speed_b, t.target_speed_c, t.target_speed_d};
		off = (t.supply_volts < volt_floor) || !t.drive_enable || t.stop_request;
		lim_eff = (lim_reg > PWM_TOP) ? PWM_TOP : lim_reg;
		bound = lim_eff <<< FRAC_BITS;
		for (w = 0; w < WHEELS; w++) begin
			cmp[7 - 2 * w] = CMP_TOP;
			cmp[6 - 2 * w] = CMP_TOP;
			if (!off) begin
				err = longint'(goal[w]) - longint'(meas[w]);
				acc = wheel_acc[w] + kp * (err - wheel_err_prev[w]) + ki * err;
				if (acc > bound)
					acc = bound;
				if (acc < -bound)
					acc = -bound;
				wheel_acc[w] = acc;
				wheel_err_prev[w] = err;
				// Truncate toward zero, not toward minus infinity.
				mag = (acc < 0) ? -acc : acc;
				drv = mag >>> FRAC_BITS;
				if (acc < 0)
					drv = -drv;
				if (drv < 0)
					cmp[6 - 2 * w] = PWM_W'(PWM_TOP + drv);
				else
					cmp[7 - 2 * w] = PWM_W'(PWM_TOP - drv);
			end
		end
		return out_req_t'(cmp);
	endfunction

	// Mostly active ticks with wheel speeds close to target, plus wide and extreme values.
	function automatic in_req_t rand_tick();
		in_req_t t;
		logic signed [SPEED_W-1:0] m [WHEELS];
		logic signed [SPEED_W-1:0] g [WHEELS];
		int base, pick, w;
		for (w = 0; w < WHEELS; w++) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					base = int'($urandom_range(0, 4000)) - 2000;
					m[w] = 16'(base);
					g[w] = 16'(base + int'($urandom_range(0, 600)) - 300);
				end
				2: begin
					m[w] = 16'($urandom);
					g[w] = 16'($urandom);
				end
				default: begin
					m[w] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
					g[w] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
				end
			endcase
		end
		t.wheel_speed_a  = m[0];
		t.wheel_speed_b  = m[1];
		t.wheel_speed_c  = m[2];
		t.wheel_speed_d  = m[3];
		t.target_speed_a = g[0];
		t.target_speed_b = g[1];
		t.target_speed_c = g[2];
		t.target_speed_d = g[3];
		t.supply_volts   = 8'($urandom_range(int'(volt_floor), 255));
		t.drive_enable   = 1'b1;
		t.stop_request   = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick >= 80) begin
			case (pick % 4)
				0: begin
					if (volt_floor > 0)
						t.supply_volts = 8'($urandom_range(0, int'(volt_floor) - 1));
					else
						t.drive_enable = 1'b0;
				end
				1: t.drive_enable = 1'b0;
				2: t.stop_request = 1'b1;
				default: begin
					t.supply_volts = 8'($urandom);
					t.drive_enable = 1'($urandom);
					t.stop_request = 1'($urandom);
				end
			endcase
		end
		return t;
	endfunction

	// Hold off new requests until every outstanding result has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		while (pwm_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_PROP_GAIN:   kp = val;
			CFG_INTEG_GAIN:  ki = val;
			CFG_PWM_LIMIT:   lim_reg = val & 16'h7FFF;
			CFG_MIN_VOLTAGE: volt_floor = val & 16'h00FF;
			default: ;
		endcase
	endtask

	// Offer one request, then queue its expected compares once it is taken.
	task automatic post_tick(in_req_t t, bit typed, out_req_t want);
		out_req_t pred;
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do
			@(posedge clk);
		while (in_stall);
		pred = pi_tick(t);
		pwm_expected.push_back(typed ? want : pred);
		ticks_sent++;
	endtask

	// Receiver back-pressure.
	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		pwm_set_t got, want;
		int i;
		if (arst_n && out_valid && !out_stall) begin
			got = pwm_set_t'(out_data);
			if (pwm_expected.size() == 0) begin
				note_fault($sformatf("unexpected result %h at %0t", out_data, $time));
			end else begin
				want = pwm_set_t'(pwm_expected.pop_front());
				checked_count++;
				for (i = 7; i >= 0; i--)
					if (got[i] !== want[i])
						note_fault($sformatf("result %0d %s: expected %0d, got %0d",
							checked_count, pwm_names[7 - i], want[i], got[i]));
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] kp_set [PHASES];
		logic [CFG_DATA_W-1:0] ki_set [PHASES];
		logic [CFG_DATA_W-1:0] lim_set [PHASES];
		logic [CFG_DATA_W-1:0] floor_set [PHASES];
		int p, n, r;

		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_pct = 0;
		stall_pct = 0;
		fault_count = 0;
		checked_count = 0;
		ticks_sent = 0;

		// Register defaults and cleared PI state, as after reset.
		kp = 0;
		ki = 0;
		lim_reg = 16700;
		volt_floor = 10;
		for (r = 0; r < WHEELS; r++) begin
			wheel_acc[r] = 0;
			wheel_err_prev[r] = 0;
		end

		// Directed part: reset defaults, drive-off conditions, saturation both ways,
		// zero and above-top limits, truncation of small negative drive.
		dir_rows = '{
			row_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 12, 1, 0), 1, PWM_ALL_TOP),
			row_tick(mk_tick(-32768, 32767, 32767, -32768, 32767, -32768, 32767, -32768,
				255, 1, 0), 1, PWM_ALL_TOP),
			row_tick(mk_tick(-32768, 32767, 5, 6, 32767, -32768, -7, 8, 9, 1, 0),
				1, PWM_ALL_TOP),
			row_tick(mk_tick(100, 200, 300, 400, -100, -200, -300, -400, 200, 0, 0),
				1, PWM_ALL_TOP),
			row_tick(mk_tick(100, 200, 300, 400, -100, -200, -300, -400, 200, 1, 1),
				1, PWM_ALL_TOP),
			row_cfg(CFG_PROP_GAIN, 16'hFFFF),
			row_cfg(CFG_INTEG_GAIN, 16'hFFFF),
			row_cfg(CFG_PWM_LIMIT, 16'h7FFF),
			row_cfg(CFG_MIN_VOLTAGE, 16'h0000),
			row_tick(mk_tick(-32768, 32767, 32767, -32768, 32767, -32768, 32767, -32768,
				0, 1, 0), 1, mk_pwm(0, PWM_TOP, PWM_TOP, 0, PWM_TOP, PWM_TOP, PWM_TOP,
				PWM_TOP)),
			row_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1,
				mk_pwm(PWM_TOP, 0, 0, PWM_TOP, PWM_TOP, PWM_TOP, PWM_TOP, PWM_TOP)),
			row_cfg(CFG_PWM_LIMIT, 16'h0000),
			row_tick(mk_tick(123, -77, 30000, -1, -4567, 9000, -30000, 1, 0, 1, 0),
				1, PWM_ALL_TOP),
			row_cfg(CFG_PWM_LIMIT, 16'(PWM_TOP)),
			row_cfg(CFG_PROP_GAIN, 16'd1),
			row_cfg(CFG_INTEG_GAIN, 16'd3),
			row_cfg(CFG_MIN_VOLTAGE, 16'd255),
			row_tick(mk_tick(1, 2, 3, 4, 50, 60, 70, 80, 254, 1, 0), 1, PWM_ALL_TOP),
			row_tick(mk_tick(1, -1, 100, -2000, 0, 0, 150, 3000, 255, 1, 0),
				0, PWM_ALL_TOP),
			row_tick(mk_tick(1, -1, 100, -2000, 0, 0, 150, 3000, 255, 1, 0),
				0, PWM_ALL_TOP),
			row_cfg(CFG_PWM_LIMIT, 16'(PWM_TOP + 1)),
			row_tick(mk_tick(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768,
				255, 1, 0), 0, PWM_ALL_TOP),
			row_tick(mk_tick(5, 5, 5, 5, -5, -5, -5, -5, 255, 0, 1), 0, PWM_ALL_TOP)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg)
				write_reg(dir_rows[r].idx, dir_rows[r].val);
			else
				post_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].want);
		end

		// Register settings per phase; the last one is drawn at random.
		kp_set    = '{16'd40, 16'd0, 16'hFFFF, 16'd300, 16'd1, 16'd1500, 16'd12, 16'd0};
		ki_set    = '{16'd8, 16'hFFFF, 16'd0, 16'd50, 16'd1, 16'd200, 16'd3, 16'd0};
		lim_set   = '{16'(PWM_TOP), 16'h7FFF, 16'd0, 16'd1000, 16'(PWM_TOP + 1), 16'd8000,
			16'd50, 16'd16700};
		floor_set = '{16'd10, 16'd0, 16'd255, 16'd20, 16'd0, 16'd100, 16'd7, 16'd40};
		kp_set[PHASES - 1]    = 16'($urandom);
		ki_set[PHASES - 1]    = 16'($urandom);
		lim_set[PHASES - 1]   = 16'($urandom_range(0, 32767));
		floor_set[PHASES - 1] = 16'($urandom_range(0, 255));

		for (p = 0; p < PHASES; p++) begin
			write_reg(CFG_PROP_GAIN, kp_set[p]);
			write_reg(CFG_INTEG_GAIN, ki_set[p]);
			write_reg(CFG_PWM_LIMIT, lim_set[p]);
			write_reg(CFG_MIN_VOLTAGE, floor_set[p]);
			// Rotate through no idling, idle sender, stalling receiver and light both.
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			for (n = 0; n < PHASE_TICKS; n++) begin
				if (p == 2 && n == PHASE_TICKS / 2)
					drain();
				post_tick(rand_tick(), 1'b0, PWM_ALL_TOP);
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d control ticks across %0d register settings and four idling mixes.",
			ticks_sent, PHASES);
		$display("Checked %0d compare sets; %0d mismatches.", checked_count, fault_count);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
